// ----- rtl/core/wcdm_pkg.sv -----
// ============================================================================
// wcdm_pkg
// Shared types, constants and helpers for the word class dictionary matcher.
// ============================================================================
package wcdm_pkg;

    // vocabulary geometry
    localparam int CATEGORY_COUNT       = 6;
    localparam int ENTRIES_PER_CATEGORY = 32;
    localparam int ENTRY_CHARS          = 16;
    localparam int SENTENCE_CHARS       = 256;
    localparam int LEN_CAP              = (SENTENCE_CHARS - 1) < 255 ? (SENTENCE_CHARS - 1) : 255;

    localparam int ROW_COUNT = CATEGORY_COUNT * ENTRIES_PER_CATEGORY;
    localparam int ROW_W     = $clog2(ROW_COUNT);
    localparam int POS_W     = $clog2(ENTRY_CHARS);
    localparam int CLEN_W    = $clog2(ENTRY_CHARS + 1);

    // field widths
    localparam int CAT_W  = 3;
    localparam int SLOT_W = 5;
    localparam int CPOS_W = 4;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 8;

    // operation codes
    localparam logic OP_DICT_WRITE = 1'b0;
    localparam logic OP_TEXT       = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ     = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ     = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CLEN_W-1:0] t_clen;
    typedef logic [ENTRY_CHARS-1:0][CHAR_W-1:0] t_entry;

    typedef struct packed {
        logic              operation;
        logic [CAT_W-1:0]  entry_category;
        logic [SLOT_W-1:0] entry_slot;
        logic [CPOS_W-1:0] char_pos;
        logic [CHAR_W-1:0] char_value;
    } t_in;

    typedef struct packed {
        logic              found;
        logic [CAT_W-1:0]  word_category;
        logic [SLOT_W-1:0] word_slot;
        logic [LEN_W-1:0]  word_length;
    } t_out;

    // request from the sequencer to the dictionary store
    typedef struct packed {
        logic              we;
        logic              clr;
        t_row              wrow;
        t_pos              wpos;
        logic [CHAR_W-1:0] wdata;
        logic              rd;
        t_row              rrow;
    } t_store_req;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_HOLD
    } t_state;

    // flat row index of a category and slot
    function automatic t_row row_of(input logic [CAT_W-1:0] cat, input logic [SLOT_W-1:0] slot);
        int idx;
        idx = int'(cat) * ENTRIES_PER_CATEGORY + int'(slot);
        return t_row'(idx);
    endfunction

endpackage

// ----- rtl/core/word_class_dictionary_matcher_unit.sv -----
// ============================================================================
// word_class_dictionary_matcher_unit
// Splits a text stream into words and looks each word up in a six-category
// dictionary, one entry per cycle through a shared comparator.
// ============================================================================
// Dictionary writes and text bytes inside a word are accepted in ST_IDLE.
// At a word end o_in_ready drops while the lookup reads one dictionary row per
// cycle from the single read port and stops at a hit or after the last row.
// Words longer than ENTRY_CHARS skip the lookup and go straight to ST_HOLD.
// Reset: a clearing pass over all ROW_COUNT rows zeroes the dictionary,
// with o_in_ready low until it ends.
module word_class_dictionary_matcher_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wcdm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wcdm_pkg::t_out o_out_data
);
    import wcdm_pkg::*;

    t_state            r_state, n_state;
    t_row              r_clr_row, n_clr_row;
    logic              r_inside, n_inside;
    logic [LEN_W-1:0]  r_len, n_len;
    t_entry            r_wbuf, n_wbuf;
    t_clen             r_cmp_len, n_cmp_len;
    t_row              r_iss_row, n_iss_row;
    logic [CAT_W-1:0]  r_iss_cat, n_iss_cat;
    logic [SLOT_W-1:0] r_iss_slot, n_iss_slot;
    logic              r_iss_done, n_iss_done;
    logic              r_rd_vld, n_rd_vld;
    logic [CAT_W-1:0]  r_cmp_cat, n_cmp_cat;
    logic [SLOT_W-1:0] r_cmp_slot, n_cmp_slot;
    logic              r_cmp_last, n_cmp_last;
    t_out              r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    t_store_req        store_req;
    t_entry            rd_row;
    logic              hit;
    logic              in_acc;
    logic              iss_last;
    logic [CHAR_W-1:0] ch;

    // dictionary memory
    wcdm_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_row)
    );

    // shared row comparator
    wcdm_cmp u_cmp (
        .i_row  (rd_row),
        .i_word (r_wbuf),
        .i_len  (r_cmp_len),
        .o_hit  (hit)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign iss_last    = (int'(r_iss_cat) == CATEGORY_COUNT - 1) &&
                         (int'(r_iss_slot) == ENTRIES_PER_CATEGORY - 1);

    // lowercase the incoming byte
    always_comb begin
        ch = i_in_data.char_value;
        if (ch inside {[CHAR_UA:CHAR_UZ]}) begin
            ch = ch + CASE_OFFSET;
        end
    end

    // sequencer: next state and store control
    always_comb begin
        n_state     = r_state;
        n_clr_row   = r_clr_row;
        n_inside    = r_inside;
        n_len       = r_len;
        n_wbuf      = r_wbuf;
        n_cmp_len   = r_cmp_len;
        n_iss_row   = r_iss_row;
        n_iss_cat   = r_iss_cat;
        n_iss_slot  = r_iss_slot;
        n_iss_done  = r_iss_done;
        n_rd_vld    = 1'b0;
        n_cmp_cat   = r_cmp_cat;
        n_cmp_slot  = r_cmp_slot;
        n_cmp_last  = r_cmp_last;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        store_req   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                store_req.we   = 1'b1;
                store_req.clr  = 1'b1;
                store_req.wrow = r_clr_row;
                n_clr_row      = r_clr_row + 1'b1;
                if (r_clr_row == t_row'(ROW_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.operation == OP_DICT_WRITE) begin
                        // dictionary byte write, ignored when out of range
                        if ((int'(i_in_data.entry_category) < CATEGORY_COUNT) &&
                            (int'(i_in_data.entry_slot) < ENTRIES_PER_CATEGORY) &&
                            (int'(i_in_data.char_pos) < ENTRY_CHARS)) begin
                            store_req.we    = 1'b1;
                            store_req.wrow  = row_of(i_in_data.entry_category,
                                                     i_in_data.entry_slot);
                            store_req.wpos  = t_pos'(i_in_data.char_pos);
                            store_req.wdata = i_in_data.char_value;
                        end
                    end else if (!r_inside) begin
                        // a letter opens a word
                        if (ch inside {[CHAR_LA:CHAR_LZ]}) begin
                            n_inside  = 1'b1;
                            n_wbuf[0] = ch;
                            n_len     = LEN_W'(1);
                        end
                    end else if (ch != CHAR_SPACE && ch != CHAR_NUL) begin
                        // byte inside a word
                        if (r_len < LEN_W'(ENTRY_CHARS)) begin
                            n_wbuf[r_len[POS_W-1:0]] = ch;
                        end
                        if (r_len < LEN_W'(LEN_CAP)) begin
                            n_len = r_len + 1'b1;
                        end
                    end else begin
                        // word end
                        n_inside          = 1'b0;
                        n_len             = '0;
                        n_res.found       = 1'b0;
                        n_res.word_category = '0;
                        n_res.word_slot   = '0;
                        n_res.word_length = r_len;
                        if (r_len <= LEN_W'(ENTRY_CHARS)) begin
                            n_cmp_len  = t_clen'(r_len);
                            n_iss_row  = '0;
                            n_iss_cat  = '0;
                            n_iss_slot = '0;
                            n_iss_done = 1'b0;
                            n_cmp_last = 1'b0;
                            n_state    = ST_SEARCH;
                        end else begin
                            n_state = ST_HOLD;
                        end
                    end
                end
            end

            ST_SEARCH: begin
                // issue one row read per cycle
                if (!r_iss_done) begin
                    store_req.rd   = 1'b1;
                    store_req.rrow = r_iss_row;
                    n_rd_vld       = 1'b1;
                    n_cmp_cat      = r_iss_cat;
                    n_cmp_slot     = r_iss_slot;
                    n_cmp_last     = iss_last;
                    n_iss_row      = r_iss_row + 1'b1;
                    if (iss_last) begin
                        n_iss_done = 1'b1;
                    end else if (int'(r_iss_slot) == ENTRIES_PER_CATEGORY - 1) begin
                        n_iss_slot = '0;
                        n_iss_cat  = r_iss_cat + 1'b1;
                    end else begin
                        n_iss_slot = r_iss_slot + 1'b1;
                    end
                end
                // compare the row read in the previous cycle
                if (r_rd_vld && hit) begin
                    n_res.found         = 1'b1;
                    n_res.word_category = r_cmp_cat;
                    n_res.word_slot     = r_cmp_slot;
                    n_state             = ST_HOLD;
                end else if (r_rd_vld && r_cmp_last) begin
                    n_state = ST_HOLD;
                end
            end

            ST_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_inside    <= 1'b0;
            r_len       <= '0;
            r_iss_done  <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_inside    <= n_inside;
            r_len       <= n_len;
            r_iss_done  <= n_iss_done;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wbuf     <= n_wbuf;
        r_cmp_len  <= n_cmp_len;
        r_iss_row  <= n_iss_row;
        r_iss_cat  <= n_iss_cat;
        r_iss_slot <= n_iss_slot;
        r_cmp_cat  <= n_cmp_cat;
        r_cmp_slot <= n_cmp_slot;
        r_cmp_last <= n_cmp_last;
        r_res      <= n_res;
        r_out      <= n_out;
    end

endmodule

// ----- rtl/core/wcdm_store.sv -----
// ============================================================================
// wcdm_store
// Dictionary memory: one row per entry, byte writes, whole-row clear,
// registered whole-row read.
// ============================================================================
module wcdm_store (
    input  logic                i_clk,
    input  wcdm_pkg::t_store_req i_req,
    output wcdm_pkg::t_entry    o_rd_data
);
    import wcdm_pkg::*;

    t_entry mem [ROW_COUNT];
    t_entry r_rd_data;

    // write port: byte lane or full-row clear
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            if (i_req.clr) begin
                mem[i_req.wrow] <= '0;
            end else begin
                mem[i_req.wrow][i_req.wpos] <= i_req.wdata;
            end
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rd_data <= mem[i_req.rrow];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/wcdm_cmp.sv -----
// ============================================================================
// wcdm_cmp
// Shared entry comparator: checks one dictionary row against the buffered
// word, requiring a terminating NUL right after the word when it is short.
// ============================================================================
module wcdm_cmp (
    input  wcdm_pkg::t_entry i_row,
    input  wcdm_pkg::t_entry i_word,
    input  wcdm_pkg::t_clen  i_len,
    output logic             o_hit
);
    import wcdm_pkg::*;

    // per-byte masked compare
    always_comb begin
        o_hit = 1'b1;
        for (int i = 0; i < ENTRY_CHARS; i++) begin
            if (i < int'(i_len)) begin
                if (i_row[i] != i_word[i]) begin
                    o_hit = 1'b0;
                end
            end else if (i == int'(i_len)) begin
                if (i_row[i] != CHAR_NUL) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

endmodule

// ----- rtl/core/wcdm_checker.sv -----
// ============================================================================
// wcdm_checker
// Port-level checks for the word class dictionary matcher, bound to the top.
// ============================================================================
module wcdm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input wcdm_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input wcdm_pkg::t_out o_out_data
);
    import wcdm_pkg::*;

    // reset starts the clearing pass with nothing pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("ready or result seen right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // a miss reports category and slot as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.word_category == '0 && o_out_data.word_slot == '0)
        else $error("miss with nonzero category or slot");

    // a hit has a word that fits an entry and a real category
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |->
            o_out_data.word_length != '0 &&
            o_out_data.word_length <= LEN_W'(ENTRY_CHARS) &&
            int'(o_out_data.word_category) < CATEGORY_COUNT)
        else $error("hit with bad length or category");

    // every result is for a nonempty word
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.word_length != '0)
        else $error("result for an empty word");

endmodule

bind word_class_dictionary_matcher_unit wcdm_checker u_wcdm_checker (.*);
